// ===== hdl/lzmd_pkg.sv =====
package lzmd_pkg;

    localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL1   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2   = 64'h94D0_49BB_1331_11EB;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HASH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_HASH = 2'd3;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_data;
        logic        run_last;
        logic        stream_end;
        logic        status;
        logic [31:0] total_out;
    } out_word_t;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [63:0] p;
        p = 64'(h ^ {24'd0, b}) * 64'(FNV_PRIME);
        return p[31:0];
    endfunction

endpackage

// ===== hdl/lzmd_if.sv =====
interface lzmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzmd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        run_last;
    logic        stream_end;
    logic        status;
    logic [31:0] total_out;

    modport source (output valid, output out_byte, output is_data, output run_last,
                    output stream_end, output status, output total_out, input ready);
    modport sink (input valid, input out_byte, input is_data, input run_last,
                  input stream_end, input status, input total_out, output ready);
endinterface

// ===== hdl/lz_masked_literal_decoder_unit.sv =====
// channel  dir  fields                                          handshake
// in_ch    in   in_byte[7:0] in_last                            valid/ready
// out_ch   out  out_byte is_data run_last stream_end status     valid/ready
//               total_out[31:0]
// cfg      in   cfg_we cfg_index[1:0] cfg_data[63:0]            write on cfg_we
//
// one compressed word at a time; ready only while idle
// tag, offset or skipped word: taken while idle; when in_last is set a status word follows via ST_FIN and ST_OWAIT
// literal: XORed with an 8-bit mask from the 64-bit mix, whose multiplies share one 32x32 multiplier
// match: each copied byte goes through history read, load, hand off and drain; 3..10 bytes
// async active-low reset clears control and stream state, history is not cleared
// a stalled output holds the sequencer until the word is taken
module lz_masked_literal_decoder_unit #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lzmd_in_if.sink                       in_ch,
    lzmd_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [lzmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lzmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lzmd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW+1)'(HISTORY_DEPTH);

    typedef enum logic [2:0] {ST_IDLE, ST_MRD, ST_MEMIT, ST_LWAIT, ST_OWAIT, ST_FIN} state_t;
    typedef enum logic [1:0] {PH_TAG, PH_OFFSET, PH_LITERAL} phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [2:0]  plen_reg, plen_next;
    logic [3:0]  phi_reg, phi_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] phash_reg, phash_next;
    logic [31:0] shash_reg, shash_next;
    logic        err_reg, err_next;
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    out_word_t   oword_reg, oword_next;

    logic [63:0] nonce_reg;
    logic [31:0] cap_reg, exp_src_reg, exp_pay_reg;

    logic        mask_start, mask_done;
    logic [7:0]  mask_val;
    logic [7:0]  ram_rdata;
    logic        emit;
    logic [7:0]  emit_val;

    logic        accept;
    logic [12:0] offset;
    logic [3:0]  mlen;
    logic [AW:0] back;
    logic        bad;

    assign accept = in_ch.valid && (state_reg == ST_IDLE);
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        plen_next   = plen_reg;
        phi_next    = phi_reg;
        left_next   = left_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        phash_next  = phash_reg;
        shash_next  = shash_reg;
        err_next    = err_reg;
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        oword_next  = oword_reg;
        mask_start  = 1'b0;
        emit        = 1'b0;
        emit_val    = ram_rdata;

        offset = {phi_reg, in_ch.in_byte} + 13'd1;
        mlen   = {1'b0, plen_reg} + 4'd3;
        back   = {1'b0, wr_reg} - (AW+1)'(offset);
        bad    = err_reg || (phase_reg == PH_OFFSET) || (phase_reg == PH_LITERAL)
                 || (exp_src_reg != 32'd0 && shash_reg != exp_src_reg)
                 || (exp_pay_reg != 32'd0 && phash_reg != exp_pay_reg);

        if (out_ch.valid && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next  = in_ch.in_byte;
                    last_next  = in_ch.in_last;
                    phash_next = fnv_step(phash_reg, in_ch.in_byte);
                    state_next = in_ch.in_last ? ST_FIN : ST_IDLE;
                    if (!err_reg)
                    begin
                        case (phase_reg)
                            PH_OFFSET:
                            begin
                                phase_next = PH_TAG;
                                if ({19'd0, offset} > count_reg ||
                                    {1'b0, count_reg} + 33'(mlen) > {1'b0, cap_reg})
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    rd_next    = back[AW] ? AW'(back + DEPTH_X) : back[AW-1:0];
                                    cnt_next   = mlen;
                                    state_next = ST_MRD;
                                end
                            end
                            PH_LITERAL:
                            begin
                                mask_start = 1'b1;
                                state_next = ST_LWAIT;
                            end
                            default:
                            begin
                                if (in_ch.in_byte[7])
                                begin
                                    plen_next  = in_ch.in_byte[6:4];
                                    phi_next   = in_ch.in_byte[3:0];
                                    phase_next = PH_OFFSET;
                                end
                                else if ({1'b0, count_reg} + 33'(in_ch.in_byte) + 33'd1
                                         > {1'b0, cap_reg})
                                begin
                                    err_next   = 1'b1;
                                    phase_next = PH_TAG;
                                end
                                else
                                begin
                                    left_next  = in_ch.in_byte + 8'd1;
                                    phase_next = PH_LITERAL;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_MRD:
            begin
                state_next = ST_MEMIT;
            end
            ST_MEMIT:
            begin
                emit       = 1'b1;
                emit_val   = ram_rdata;
                oword_next.run_last = (cnt_reg == 4'd1) && !last_reg;
                rd_next    = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
                cnt_next   = cnt_reg - 4'd1;
                state_next = ST_OWAIT;
            end
            ST_LWAIT:
            begin
                if (mask_done)
                begin
                    emit      = 1'b1;
                    emit_val  = byte_reg ^ mask_val;
                    oword_next.run_last = !last_reg;
                    pos_next  = pos_reg + 32'd1;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_TAG;
                    end
                    cnt_next   = 4'd0;
                    state_next = ST_OWAIT;
                end
            end
            ST_OWAIT:
            begin
                if (!ovalid_reg)
                begin
                    if (cnt_reg != 4'd0)
                    begin
                        state_next = ST_MRD;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN:
            begin
                // status word, then the stream starts over
                ovalid_next = 1'b1;
                oword_next  = '{out_byte: 8'd0, is_data: 1'b0, run_last: 1'b1,
                                stream_end: 1'b1, status: bad, total_out: count_reg};
                count_next  = 32'd0;
                pos_next    = 32'd0;
                phase_next  = PH_TAG;
                plen_next   = 3'd0;
                phi_next    = 4'd0;
                left_next   = 8'd0;
                phash_next  = FNV_BASIS;
                shash_next  = FNV_BASIS;
                err_next    = 1'b0;
                wr_next     = '0;
                last_next   = 1'b0;
                cnt_next    = 4'd0;
                state_next  = ST_OWAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            ovalid_next         = 1'b1;
            oword_next.out_byte   = emit_val;
            oword_next.is_data    = 1'b1;
            oword_next.stream_end = 1'b0;
            oword_next.status     = 1'b0;
            oword_next.total_out  = 32'd0;
            shash_next = fnv_step(shash_reg, emit_val);
            count_next = count_reg + 32'd1;
            wr_next    = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_TAG;
            last_reg    <= 1'b0;
            plen_reg    <= 3'd0;
            phi_reg     <= 4'd0;
            left_reg    <= 8'd0;
            count_reg   <= 32'd0;
            pos_reg     <= 32'd0;
            phash_reg   <= FNV_BASIS;
            shash_reg   <= FNV_BASIS;
            err_reg     <= 1'b0;
            wr_reg      <= '0;
            rd_reg      <= '0;
            cnt_reg     <= 4'd0;
            ovalid_reg  <= 1'b0;
            nonce_reg   <= 64'd0;
            cap_reg     <= 32'hFFFF_FFFF;
            exp_src_reg <= 32'd0;
            exp_pay_reg <= 32'd0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            last_reg    <= last_next;
            plen_reg    <= plen_next;
            phi_reg     <= phi_next;
            left_reg    <= left_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            phash_reg   <= phash_next;
            shash_reg   <= shash_next;
            err_reg     <= err_next;
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NONCE:        nonce_reg   <= cfg_data;
                    CFG_CAPACITY:     cap_reg     <= cfg_data[31:0];
                    CFG_SOURCE_HASH:  exp_src_reg <= cfg_data[31:0];
                    CFG_PAYLOAD_HASH: exp_pay_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        oword_reg <= oword_next;
    end

    lzmd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (emit),
        .waddr (wr_reg),
        .wdata (emit_val),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    lzmd_mask u_mask (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mask_start),
        .key   (nonce_reg),
        .pos   (pos_reg),
        .done  (mask_done),
        .mask  (mask_val)
    );

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.out_byte   = oword_reg.out_byte;
    assign out_ch.is_data    = oword_reg.is_data;
    assign out_ch.run_last   = oword_reg.run_last;
    assign out_ch.stream_end = oword_reg.stream_end;
    assign out_ch.status     = oword_reg.status;
    assign out_ch.total_out  = oword_reg.total_out;
endmodule

// ===== hdl/lzmd_ram.sv =====
module lzmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/lzmd_mask.sv =====
module lzmd_mask (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [31:0] pos,
    output logic        done,
    output logic [7:0]  mask
);
    import lzmd_pkg::*;

    logic        run_reg, run_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  sub_reg, sub_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic        done_reg, done_next;
    logic [7:0]  mask_reg, mask_next;

    logic [63:0] k;
    logic [31:0] mul_a, mul_b;
    logic [31:0] hi_sum;
    logic [63:0] r, t;

    always_comb
    begin
        case (phase_reg)
            2'd2:    k = MIX_MUL2;
            default: k = MIX_MUL1;
        endcase
        mul_a = (sub_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
        mul_b = (sub_reg == 2'd1) ? k[63:32] : k[31:0];
        prod_next = 64'(mul_a) * 64'(mul_b);
        hi_sum = acc_reg[63:32] + prod_reg[31:0];
        r = {hi_sum, acc_reg[31:0]};

        run_next   = run_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        mask_next  = mask_reg;
        t          = r;

        if (start)
        begin
            run_next   = 1'b1;
            phase_next = 2'd0;
            sub_next   = 2'd0;
            v_next     = {32'd0, pos};
        end
        else if (run_reg)
        begin
            sub_next = sub_reg + 2'd1;
            case (sub_reg)
                2'd1:    acc_next = prod_reg;
                2'd2:    acc_next = r;
                2'd3:
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            t = key ^ (MIX_GOLDEN + r);
                            v_next = t ^ (t >> 30);
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            v_next = t ^ (t >> 27);
                            phase_next = 2'd2;
                        end
                        default:
                        begin
                            v_next = t ^ (t >> 31);
                            mask_next = v_next[7:0];
                            done_next = 1'b1;
                            run_next = 1'b0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 2'd0;
            sub_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        mask_reg <= mask_next;
    end

    assign done = done_reg;
    assign mask = mask_reg;
endmodule
